[sv/dcue_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcue_pkg
// Shared types and constants for the down counter uptime extender.
// ----------------------------------------------------------------------------
package dcue_pkg;

	localparam int DCUE_CNT_BITS    = 24;
	localparam int DCUE_WRAP_BITS   = 32;
	localparam int DCUE_TOTAL_BITS  = DCUE_CNT_BITS + DCUE_WRAP_BITS;
	localparam int DCUE_SEC_BITS    = 37;
	localparam int DCUE_FRAC_BITS   = 10;
	localparam int DCUE_MHZ_BITS    = 8;
	localparam int DCUE_PER_MS_BITS = 18;
	localparam int DCUE_PER_S_BITS  = 28;

	localparam int DCUE_CYC_PER_MS  = 1000;
	localparam int DCUE_CYC_PER_S   = 1000000;

	localparam logic [DCUE_MHZ_BITS-1:0] DCUE_MHZ_RESET = DCUE_MHZ_BITS'(32);
	localparam int DCUE_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [DCUE_CNT_BITS-1:0] counter_sample;
		logic [DCUE_CNT_BITS-1:0] reference_sample;
	} dcue_in_t;

	typedef struct packed {
		logic [DCUE_CNT_BITS-1:0]   elapsed_cycles;
		logic [DCUE_TOTAL_BITS-1:0] uptime_cycles;
		logic [DCUE_SEC_BITS-1:0]   seconds;
		logic [DCUE_FRAC_BITS-1:0]  milliseconds;
		logic [DCUE_FRAC_BITS-1:0]  microseconds;
	} dcue_out_t;

	// work passed from front end to back end
	typedef struct packed {
		logic [DCUE_CNT_BITS-1:0]   elapsed;
		logic [DCUE_TOTAL_BITS-1:0] total;
	} dcue_job_t;

	// divisors derived from the clock setting
	typedef struct packed {
		logic [DCUE_PER_S_BITS-1:0]  per_s;
		logic [DCUE_PER_MS_BITS-1:0] per_ms;
		logic [DCUE_MHZ_BITS-1:0]    per_us;
	} dcue_div_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dcue_q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEC,
		ST_MS,
		ST_US,
		ST_FIN
	} dcue_state_t;

endpackage

[sv/dcue_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcue_front
// Takes samples, tracks wraps of the down counter and forms the wide count.
// ----------------------------------------------------------------------------
module dcue_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  dcue_pkg::dcue_in_t     sample,
	input  dcue_pkg::dcue_q_status_t q_status,
	output logic                   push,
	output dcue_pkg::dcue_job_t    push_job
);
	import dcue_pkg::*;

	logic [DCUE_CNT_BITS-1:0]  prev_q;
	logic [DCUE_WRAP_BITS-1:0] wrap_q;
	logic [DCUE_WRAP_BITS-1:0] wrap_nxt;
	logic [DCUE_CNT_BITS-1:0]  now;

	assign now          = sample.counter_sample;
	assign sample_ready = !q_status.full;
	assign push         = sample_valid && !q_status.full;

	// a down counter that goes up has wrapped
	assign wrap_nxt = (now > prev_q) ? wrap_q + DCUE_WRAP_BITS'(1) : wrap_q;

	always_comb begin
		push_job.elapsed = sample.reference_sample - now;
		push_job.total   = {wrap_nxt, ~now};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			wrap_q <= '0;
		end else if (push) begin
			prev_q <= now;
			wrap_q <= wrap_nxt;
		end
	end

endmodule

[sv/dcue_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcue_queue
// Small first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module dcue_queue #(
	parameter int DEPTH = dcue_pkg::DCUE_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  dcue_pkg::dcue_job_t      push_job,
	input  logic                     pop,
	output dcue_pkg::dcue_job_t      head_job,
	output dcue_pkg::dcue_q_status_t status
);
	import dcue_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dcue_job_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head_job     = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("request pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("request popped from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

[sv/dcue_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcue_back
// Splits the wide count into seconds, milliseconds and microseconds with one
// shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcue_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dcue_pkg::dcue_div_cfg_t  div_cfg,
	input  dcue_pkg::dcue_q_status_t q_status,
	input  dcue_pkg::dcue_job_t      head_job,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_ready,
	output dcue_pkg::dcue_out_t      result
);
	import dcue_pkg::*;

	localparam int SEC_STEPS = DCUE_TOTAL_BITS;
	localparam int FRAC_STEPS = DCUE_FRAC_BITS;
	localparam int CW = $clog2(SEC_STEPS);
	localparam int RW = DCUE_PER_S_BITS + 1;

	dcue_state_t state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic          last_sec, last_frac, load_out;

	logic [DCUE_CNT_BITS-1:0]   elapsed_q;
	logic [DCUE_TOTAL_BITS-1:0] total_q;
	logic [DCUE_SEC_BITS-1:0]   secs_q;
	logic [DCUE_FRAC_BITS-1:0]  ms_q;
	logic [RW-1:0]              rem_q, rem_nxt, trial;
	logic [DCUE_TOTAL_BITS-1:0] sh_q, sh_nxt;
	logic [DCUE_PER_S_BITS-1:0] divisor;
	logic [RW:0]                diff;
	logic                       ge;

	dcue_out_t result_q;
	logic      result_valid_q;

	assign last_sec  = (cnt_q == CW'(SEC_STEPS - 1));
	assign last_frac = (cnt_q == CW'(FRAC_STEPS - 1));

	always_comb begin
		case (state_q)
			ST_SEC:  divisor = div_cfg.per_s;
			ST_MS:   divisor = DCUE_PER_S_BITS'(div_cfg.per_ms);
			default: divisor = DCUE_PER_S_BITS'(div_cfg.per_us);
		endcase
	end

	// one restoring step: bring down the next dividend bit, try to subtract
	assign trial   = {rem_q[RW-2:0], sh_q[DCUE_TOTAL_BITS-1]};
	assign diff    = {1'b0, trial} - {2'b0, divisor};
	assign ge      = !diff[RW];
	assign rem_nxt = ge ? diff[RW-1:0] : trial;
	assign sh_nxt  = {sh_q[DCUE_TOTAL_BITS-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					pop       = 1'b1;
					state_nxt = ST_SEC;
				end
			end
			ST_SEC: begin
				if (last_sec)
					state_nxt = ST_MS;
			end
			ST_MS: begin
				if (last_frac)
					state_nxt = ST_US;
			end
			ST_US: begin
				if (last_frac)
					state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (!result_valid_q || result_ready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if ((state_q == ST_SEC && !last_sec) ||
			    ((state_q == ST_MS || state_q == ST_US) && !last_frac))
				cnt_q <= cnt_q + CW'(1);
			else
				cnt_q <= '0;
		end
	end

	// the remainder of each stage is split as the next stage's dividend
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					elapsed_q <= head_job.elapsed;
					total_q   <= head_job.total;
					rem_q     <= '0;
					sh_q      <= head_job.total;
				end
			end
			ST_SEC: begin
				if (last_sec) begin
					secs_q <= sh_nxt[DCUE_SEC_BITS-1:0];
					rem_q  <= rem_nxt >> FRAC_STEPS;
					sh_q   <= {rem_nxt[FRAC_STEPS-1:0], {(SEC_STEPS-FRAC_STEPS){1'b0}}};
				end else begin
					rem_q <= rem_nxt;
					sh_q  <= sh_nxt;
				end
			end
			ST_MS: begin
				if (last_frac) begin
					ms_q  <= sh_nxt[FRAC_STEPS-1:0];
					rem_q <= rem_nxt >> FRAC_STEPS;
					sh_q  <= {rem_nxt[FRAC_STEPS-1:0], {(SEC_STEPS-FRAC_STEPS){1'b0}}};
				end else begin
					rem_q <= rem_nxt;
					sh_q  <= sh_nxt;
				end
			end
			ST_US: begin
				rem_q <= rem_nxt;
				sh_q  <= sh_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.elapsed_cycles <= elapsed_q;
			result_q.uptime_cycles  <= total_q;
			result_q.seconds        <= secs_q;
			result_q.milliseconds   <= ms_q;
			result_q.microseconds   <= sh_q[FRAC_STEPS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (load_out)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEC || state_q == ST_MS || state_q == ST_US) |->
		(rem_q < {1'b0, divisor}))
		else $error("partial remainder not below divisor");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |->
		(result_q.milliseconds < DCUE_FRAC_BITS'(DCUE_CYC_PER_MS) &&
		 result_q.microseconds < DCUE_FRAC_BITS'(DCUE_CYC_PER_MS)))
		else $error("sub-second field out of range");

endmodule

[sv/down_counter_uptime_extender_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// down_counter_uptime_extender_core
// Extends a free-running 24-bit down counter into a 56-bit uptime count and
// splits it into seconds, milliseconds and microseconds.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                     | carries
//  ---------+-------------------------------+----------------------------------
//  sample   | sample_valid / sample_ready   | counter and reference samples
//  result   | result_valid / result_ready   | elapsed, total, s, ms, us
//  cfg      | cfg_valid / cfg_ready         | clock in MHz (always ready)
//
//  the front end takes a sample and queues it (two entries by default)
//  for each sample the back end fetches it, runs 56 seconds steps,
//  ten millisecond steps and ten microsecond steps of the shared divider,
//  hands over to the output register and only then takes the next sample
//  a held output stalls only the hand-over; reset needs no clearing pass
//
module down_counter_uptime_extender_core #(
	parameter int QUEUE_DEPTH = dcue_pkg::DCUE_QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  dcue_pkg::dcue_in_t                  sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output dcue_pkg::dcue_out_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dcue_pkg::DCUE_MHZ_BITS-1:0]  cfg_data
);
	import dcue_pkg::*;

	dcue_div_cfg_t  div_cfg_q;
	logic [DCUE_MHZ_BITS-1:0] mhz_eff;
	dcue_q_status_t q_status;
	dcue_job_t      push_job, head_job;
	logic           push, pop;

	assign cfg_ready = 1'b1;

	// a zero clock setting counts as one megahertz
	assign mhz_eff = (cfg_data == '0) ? DCUE_MHZ_BITS'(1) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cfg_q.per_us <= DCUE_MHZ_RESET;
			div_cfg_q.per_ms <= DCUE_PER_MS_BITS'(int'(DCUE_MHZ_RESET) * DCUE_CYC_PER_MS);
			div_cfg_q.per_s  <= DCUE_PER_S_BITS'(int'(DCUE_MHZ_RESET) * DCUE_CYC_PER_S);
		end else if (cfg_valid) begin
			div_cfg_q.per_us <= mhz_eff;
			div_cfg_q.per_ms <= DCUE_PER_MS_BITS'(DCUE_PER_MS_BITS'(mhz_eff) *
			                                      DCUE_PER_MS_BITS'(DCUE_CYC_PER_MS));
			div_cfg_q.per_s  <= DCUE_PER_S_BITS'(DCUE_PER_S_BITS'(mhz_eff) *
			                                     DCUE_PER_S_BITS'(DCUE_CYC_PER_S));
		end
	end

	dcue_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.q_status     (q_status),
		.push         (push),
		.push_job     (push_job)
	);

	dcue_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	dcue_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.div_cfg      (div_cfg_q),
		.q_status     (q_status),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
